@@ src/sos_pkg.sv @@
// Shared constants for the set-of-stacks unit: geometry, derived widths,
// request and status codes. Depends on nothing.
`default_nettype none
package sos_pkg;

   // Geometry of the bank
   localparam int SUB_DEPTH = 16;
   localparam int NUM_SUBS  = 8;
   localparam int NUM_WORDS = SUB_DEPTH * NUM_SUBS;

   // Derived widths
   localparam int SUB_W   = $clog2(NUM_SUBS > 1 ? NUM_SUBS : 2);
   localparam int FILL_W  = $clog2(SUB_DEPTH + 1);
   localparam int WADDR_W = $clog2(NUM_WORDS > 1 ? NUM_WORDS : 2);

   // Request codes
   localparam logic [1:0] CMD_PUSH   = 2'd0;
   localparam logic [1:0] CMD_POP    = 2'd1;
   localparam logic [1:0] CMD_POP_AT = 2'd2;
   localparam logic [1:0] CMD_PEEK   = 2'd3;

   // Status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // Word address of a slot inside a sub-stack
   function automatic logic [WADDR_W-1:0] word_addr(input logic [SUB_W-1:0] sub,
                                                    input int slot);
      word_addr = WADDR_W'(int'(sub) * SUB_DEPTH + slot);
   endfunction

endpackage
`default_nettype wire

@@ src/sos_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
`default_nettype none
module sos_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  wire logic                                       clock,
   input  wire logic                                       wr_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]                           wr_data,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]   rd_addr,
   output logic      [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, registered read data
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

@@ src/set_of_stacks_unit.sv @@
// Set-of-stacks unit top level: request sequencer around a word store RAM and
// a fill count RAM. Depends on sos_pkg and sos_ram.
//
// A request is taken when start is high and busy is low; its single result
// shows on the rsp_ ports for one cycle with rsp_valid high, and the receiver
// cannot stall it. A push reads the fill count and then writes the word (it
// first moves on to the next sub-stack when the current one is full); pop at
// sub-stack reads the fill count and then the word; pop and peek first step
// back over empty sub-stacks, reading one fill count per cycle through the
// fill count RAM's single read port. A pop or peek that finds every sub-stack
// empty steps back from the current sub-stack down to sub-stack 0 before it
// reports empty. No clearing pass follows reset.
`default_nettype none
module set_of_stacks_unit
   import sos_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic        [1:0]  req_cmd,
   input  wire logic signed [31:0] req_push_value,
   input  wire logic        [2:0]  req_sub_index,
   output logic                    rsp_valid,
   output logic signed      [31:0] rsp_out_value,
   output logic             [1:0]  rsp_status
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_FILL = 2'd1;
   localparam logic [1:0] S_WORD = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [1:0]          cmd_ff, cmd_in;
   logic [31:0]         val_ff, val_in;
   logic [SUB_W-1:0]    sub_ff, sub_in;
   logic [SUB_W-1:0]    cur_ff, cur_in;
   logic [FILL_W-1:0]   cnt_ff, cnt_in;
   logic [NUM_SUBS-1:0] fvld_ff, fvld_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [31:0]         rsp_value_ff, rsp_value_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;

   logic                word_we;
   logic [WADDR_W-1:0]  word_waddr, word_raddr;
   logic [31:0]         word_rdata;
   logic                fill_we;
   logic [SUB_W-1:0]    fill_waddr, fill_raddr;
   logic [FILL_W-1:0]   fill_wdata, fill_rdata, fill_cur;
   logic                bad_index;

   sos_ram #(.WIDTH(32), .DEPTH(NUM_WORDS)) u_word_ram (
      .clock   (clock),
      .wr_en   (word_we),
      .wr_addr (word_waddr),
      .wr_data (val_ff),
      .rd_addr (word_raddr),
      .rd_data (word_rdata)
   );

   sos_ram #(.WIDTH(FILL_W), .DEPTH(NUM_SUBS)) u_fill_ram (
      .clock   (clock),
      .wr_en   (fill_we),
      .wr_addr (fill_waddr),
      .wr_data (fill_wdata),
      .rd_addr (fill_raddr),
      .rd_data (fill_rdata)
   );

   // Unwritten fill counts read as zero
   assign fill_cur  = fvld_ff[sub_ff] ? fill_rdata : '0;
   assign bad_index = int'(req_sub_index) >= NUM_SUBS;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      val_in        = val_ff;
      sub_in        = sub_ff;
      cur_in        = cur_ff;
      cnt_in        = cnt_ff;
      fvld_in       = fvld_ff;
      rsp_valid_in  = 1'b0;
      rsp_value_in  = '0;
      rsp_status_in = ST_OK;
      word_we       = 1'b0;
      word_waddr    = word_addr(sub_ff, int'(fill_cur));
      word_raddr    = word_addr(sub_ff, int'(fill_cur) - 1);
      fill_we       = 1'b0;
      fill_waddr    = sub_ff;
      fill_wdata    = FILL_W'(int'(fill_cur) + 1);
      fill_raddr    = sub_ff;
      case (state_ff)
         S_IDLE: begin
            fill_raddr = (req_cmd == CMD_POP_AT) ? SUB_W'(req_sub_index) : cur_ff;
            if (start) begin
               cmd_in = req_cmd;
               val_in = req_push_value;
               sub_in = fill_raddr;
               if (req_cmd == CMD_POP_AT && bad_index) begin
                  // drop a pop at a sub-stack that does not exist
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_EMPTY;
               end else begin
                  state_in = S_FILL;
               end
            end
         end
         S_FILL: begin
            cnt_in = fill_cur;
            case (cmd_ff)
               CMD_PUSH: begin
                  if (fill_cur >= FILL_W'(SUB_DEPTH) && sub_ff != cur_ff) begin
                     // already advanced: write regardless, as the bank does
                     word_we    = 1'b1;
                     fill_we    = 1'b1;
                     fvld_in[sub_ff] = 1'b1;
                     rsp_valid_in = 1'b1;
                     state_in   = S_IDLE;
                  end else if (fill_cur >= FILL_W'(SUB_DEPTH)) begin
                     if (sub_ff == SUB_W'(NUM_SUBS - 1)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_FULL;
                        state_in      = S_IDLE;
                     end else begin
                        // advance to the next sub-stack and read its count
                        sub_in     = sub_ff + 1'b1;
                        cur_in     = sub_ff + 1'b1;
                        fill_raddr = sub_ff + 1'b1;
                     end
                  end else begin
                     word_we    = 1'b1;
                     fill_we    = 1'b1;
                     fvld_in[sub_ff] = 1'b1;
                     rsp_valid_in = 1'b1;
                     state_in   = S_IDLE;
                  end
               end
               CMD_POP_AT: begin
                  if (fill_cur == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_EMPTY;
                     state_in      = S_IDLE;
                  end else begin
                     state_in = S_WORD;
                  end
               end
               default: begin
                  // pop and peek: step back over empty sub-stacks
                  if (fill_cur != '0) begin
                     cur_in   = sub_ff;
                     state_in = S_WORD;
                  end else if (sub_ff == '0) begin
                     cur_in        = '0;
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_EMPTY;
                     state_in      = S_IDLE;
                  end else begin
                     sub_in     = sub_ff - 1'b1;
                     fill_raddr = sub_ff - 1'b1;
                  end
               end
            endcase
         end
         S_WORD: begin
            // deliver the top word and shrink the count unless peeking
            fill_wdata   = cnt_ff - 1'b1;
            fill_we      = (cmd_ff != CMD_PEEK);
            rsp_valid_in = 1'b1;
            rsp_value_in = word_rdata;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_ff       <= '0;
         fvld_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         fvld_ff      <= fvld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      val_ff        <= val_in;
      sub_ff        <= sub_in;
      cnt_ff        <= cnt_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy          = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;

endmodule
`default_nettype wire
